/* design/taw_pkg.sv */
// Shared definitions for the threshold alarm with window block.
// Level codes, compare modes, register indexes, config and cell control structs.
// No dependencies.
package taw_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int DATA_W  = 32;
    localparam int LEVEL_W = 2;
    localparam int MODE_W  = 2;
    localparam int WCNT_W  = 7;
    localparam int TALLY_W = 16;
    localparam int WSIZE_W = 7;
    localparam int INDEX_W = 3;

    // Class and report level codes
    localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_WARN   = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_CRIT   = 2'd2;

    // Compare modes; the unused code behaves as at-or-above
    localparam logic [MODE_W-1:0] CMP_LE = 2'd0;
    localparam logic [MODE_W-1:0] CMP_EQ = 2'd1;
    localparam logic [MODE_W-1:0] CMP_GE = 2'd2;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_COMPARE_MODE  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_WARN_ENABLE   = 3'd1;
    localparam logic [INDEX_W-1:0] REG_WARN_LEVEL    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_CRIT_ENABLE   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_CRIT_LEVEL    = 3'd4;
    localparam logic [INDEX_W-1:0] REG_WARN_COUNT    = 3'd5;
    localparam logic [INDEX_W-1:0] REG_RECOVER_COUNT = 3'd6;
    localparam logic [INDEX_W-1:0] REG_WINDOW_SIZE   = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0]        compare_mode;
        logic                     warn_enable;
        logic signed [DATA_W-1:0] warn_level;
        logic                     crit_enable;
        logic signed [DATA_W-1:0] crit_level;
    } class_cfg_t;

    typedef struct packed {
        logic write;   // write a mark at the token cell and pass the token
        logic clear;   // zero every mark and return the token to cell 0
        logic mark;    // mark value to write
        logic stray;   // no cell in use holds the token
    } cell_ctl_t;

endpackage

/* design/taw_class.sv */
// Sample classifier: compares a sample with the warning and critical levels.
// Depends on taw_pkg.
module taw_class
(
    input  logic signed [taw_pkg::DATA_W-1:0]  sample,
    input  taw_pkg::class_cfg_t                cfg,
    output logic        [taw_pkg::LEVEL_W-1:0] cls
);

    function automatic logic level_hit(
        input logic signed [taw_pkg::DATA_W-1:0] s,
        input logic signed [taw_pkg::DATA_W-1:0] l,
        input logic [taw_pkg::MODE_W-1:0]        mode
    );
        logic hit;
        case (mode)
            taw_pkg::CMP_LE: hit = (s <= l);
            taw_pkg::CMP_EQ: hit = (s == l);
            default:         hit = (s >= l);
        endcase
        return hit;
    endfunction

    logic warn_hit;
    logic crit_hit;

    assign warn_hit = cfg.warn_enable && level_hit(sample, cfg.warn_level, cfg.compare_mode);
    assign crit_hit = cfg.crit_enable && level_hit(sample, cfg.crit_level, cfg.compare_mode);

    // Critical overrides warning
    always_comb
    begin
        if (crit_hit)
        begin
            cls = taw_pkg::LVL_CRIT;
        end
        else if (warn_hit)
        begin
            cls = taw_pkg::LVL_WARN;
        end
        else
        begin
            cls = taw_pkg::LVL_NORMAL;
        end
    end

endmodule

/* design/taw_cell.sv */
// One window cell: a mark bit, the write token, and a stage of the mark count chain.
// Depends on taw_pkg.
module taw_cell
#(
    parameter int IDX = 0,
    parameter int SW  = 7,
    parameter int CW  = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SW-1:0]         size_eff,
    input  taw_pkg::cell_ctl_t    ctl,
    input  logic                  tok_in,
    input  logic [CW-1:0]         psum_in,
    output logic                  hold,
    output logic                  pass,
    output logic                  wrap_hit,
    output logic                  old_hit,
    output logic [CW-1:0]         psum
);

    logic          tok_reg;
    logic          tok_next;
    logic          mark_reg;
    logic          mark_next;
    logic [CW-1:0] psum_reg;
    logic          in_use;
    logic          last;
    logic          here;

    assign in_use = (SW'(IDX) < size_eff);
    assign last   = (SW'(IDX + 1) == size_eff);

    // A token left beyond a shrunk window lands on cell 0
    assign hold     = tok_reg && in_use;
    assign here     = hold || ((IDX == 0) && ctl.stray);
    assign pass     = here && !last;
    assign wrap_hit = here && last;
    assign old_hit  = here && mark_reg;
    assign psum     = psum_reg;

    always_comb
    begin
        tok_next  = tok_reg;
        mark_next = mark_reg;
        if (ctl.clear)
        begin
            tok_next  = (IDX == 0);
            mark_next = 1'b0;
        end
        else if (ctl.write)
        begin
            tok_next = tok_in;
            if (here)
            begin
                mark_next = ctl.mark;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= (IDX == 0);
            mark_reg <= 1'b0;
        end
        else
        begin
            tok_reg  <= tok_next;
            mark_reg <= mark_next;
        end
    end

    // Running partial count; settles along the row after a window resize
    always_ff @(posedge clk)
    begin
        psum_reg <= psum_in + CW'(mark_reg && in_use);
    end

endmodule

/* design/threshold_alarm_with_window_unit.sv */
// Top level of the threshold alarm with window block.
// Depends on taw_pkg, taw_class and taw_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries one signed sample per transaction.
//   Output channel out_valid/out_stall carries one result per sample: the
//   sample's class, whether it changed, and an optional level report.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data while the
//   block is idle; a write takes effect at the next clock edge.
// Pipeline: a classify stage, then the window update stage into the output
//   register.
// Throughput: one sample per cycle while out_stall is low and no recount runs:
//   the mark count is kept incrementally, so each cell row write is one step.
// Writing window_size holds in_stall high while the mark count is recounted
//   along the cell row.
// Reset: the configuration and state registers return to their reset values,
//   the window is empty, the reported level is normal and no result is pending.
// Stall: while out_stall is high the result holds; one more sample is taken
//   into the classify stage, then in_stall rises until the result is taken.
module threshold_alarm_with_window_unit
#(
    parameter int WINDOW_MAX = taw_pkg::WINDOW_MAX_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [taw_pkg::DATA_W-1:0]     sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic        [taw_pkg::LEVEL_W-1:0]    check_level,
    output logic                                  level_changed,
    output logic                                  report_valid,
    output logic        [taw_pkg::LEVEL_W-1:0]    report_level,
    input  logic                                  cfg_wr_en,
    input  logic        [taw_pkg::INDEX_W-1:0]    cfg_index,
    input  logic        [taw_pkg::DATA_W-1:0]     cfg_data
);

    localparam int SW       = $clog2(WINDOW_MAX + 1);
    localparam int CW       = SW;
    localparam int YW       = $clog2(WINDOW_MAX + 2);
    localparam int SYNC_LEN = WINDOW_MAX + 1;

    localparam int LW = taw_pkg::LEVEL_W;
    localparam int TW = taw_pkg::TALLY_W;

    // Configuration registers
    logic [taw_pkg::MODE_W-1:0]         compare_mode_reg;
    logic                               warn_enable_reg;
    logic signed [taw_pkg::DATA_W-1:0]  warn_level_reg;
    logic                               crit_enable_reg;
    logic signed [taw_pkg::DATA_W-1:0]  crit_level_reg;
    logic [taw_pkg::WCNT_W-1:0]         warn_count_reg;
    logic [TW-1:0]                      recover_count_reg;
    logic [taw_pkg::WSIZE_W-1:0]        window_size_reg;
    logic [YW-1:0]                      sync_reg;

    // Pipeline and state
    logic          s1_valid_reg;
    logic [LW-1:0] s1_cls_reg;
    logic [LW-1:0] s1_cls;
    logic [LW-1:0] prev_cls_reg;
    logic [LW-1:0] rep_reg;
    logic [LW-1:0] rep_next;
    logic [TW-1:0] tally_reg;
    logic [TW-1:0] tally_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          out_valid_reg;
    logic [LW-1:0] check_level_reg;
    logic          level_changed_reg;
    logic          report_valid_reg;
    logic [LW-1:0] report_level_reg;

    taw_pkg::class_cfg_t class_cfg;
    taw_pkg::cell_ctl_t  cell_ctl;

    logic          in_accept;
    logic          out_free;
    logic          adv;
    logic [SW-1:0] size_eff;

    logic [WINDOW_MAX-1:0] hold_v;
    logic [WINDOW_MAX-1:0] pass_v;
    logic [WINDOW_MAX-1:0] wrap_v;
    logic [WINDOW_MAX-1:0] old_v;
    logic [WINDOW_MAX-1:0] tok_in_v;
    logic [CW-1:0]         psum_v    [WINDOW_MAX];
    logic [CW-1:0]         psum_in_v [WINDOW_MAX];

    logic          is_crit;
    logic          is_norm;
    logic          new_mark;
    logic          old_mark;
    logic [CW-1:0] cnt_after;
    logic          recover_hit;
    logic          clear_now;
    logic          raise;
    logic [LW-1:0] target;
    logic          rep_valid;
    logic [LW-1:0] rep_level;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign adv       = s1_valid_reg && out_free;
    assign in_stall  = (s1_valid_reg && !out_free) || (sync_reg != '0);
    assign in_accept = in_valid && !in_stall;

    // Configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_mode_reg  <= taw_pkg::CMP_GE;
            warn_enable_reg   <= 1'b0;
            warn_level_reg    <= '0;
            crit_enable_reg   <= 1'b0;
            crit_level_reg    <= '0;
            warn_count_reg    <= taw_pkg::WCNT_W'(1);
            recover_count_reg <= TW'(1);
            window_size_reg   <= taw_pkg::WSIZE_W'(1);
            sync_reg          <= '0;
        end
        else
        begin
            if (sync_reg != '0)
            begin
                sync_reg <= sync_reg - YW'(1);
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    taw_pkg::REG_COMPARE_MODE:  compare_mode_reg  <= cfg_data[taw_pkg::MODE_W-1:0];
                    taw_pkg::REG_WARN_ENABLE:   warn_enable_reg   <= cfg_data[0];
                    taw_pkg::REG_WARN_LEVEL:    warn_level_reg    <= cfg_data;
                    taw_pkg::REG_CRIT_ENABLE:   crit_enable_reg   <= cfg_data[0];
                    taw_pkg::REG_CRIT_LEVEL:    crit_level_reg    <= cfg_data;
                    taw_pkg::REG_WARN_COUNT:    warn_count_reg    <= cfg_data[taw_pkg::WCNT_W-1:0];
                    taw_pkg::REG_RECOVER_COUNT: recover_count_reg <= cfg_data[TW-1:0];
                    taw_pkg::REG_WINDOW_SIZE:
                    begin
                        window_size_reg <= cfg_data[taw_pkg::WSIZE_W-1:0];
                        sync_reg        <= YW'(SYNC_LEN);
                    end
                    default: ;
                endcase
            end
        end
    end

    // Clamp the window size to 1..WINDOW_MAX
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            size_eff = SW'(1);
        end
        else if (32'(window_size_reg) > 32'(WINDOW_MAX))
        begin
            size_eff = SW'(WINDOW_MAX);
        end
        else
        begin
            size_eff = SW'(window_size_reg);
        end
    end

    // Stage 1: classify
    assign class_cfg.compare_mode = compare_mode_reg;
    assign class_cfg.warn_enable  = warn_enable_reg;
    assign class_cfg.warn_level   = warn_level_reg;
    assign class_cfg.crit_enable  = crit_enable_reg;
    assign class_cfg.crit_level   = crit_level_reg;

    taw_class u_class
    (
        .sample (sample),
        .cfg    (class_cfg),
        .cls    (s1_cls)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cls_reg <= s1_cls;
        end
    end

    // Cell row
    assign tok_in_v[0]  = |wrap_v;
    assign psum_in_v[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_MAX; gi++)
        begin : g_cell
            if (gi > 0)
            begin : g_link
                assign tok_in_v[gi]  = pass_v[gi-1];
                assign psum_in_v[gi] = psum_v[gi-1];
            end

            taw_cell
            #(
                .IDX (gi),
                .SW  (SW),
                .CW  (CW)
            )
            u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .size_eff (size_eff),
                .ctl      (cell_ctl),
                .tok_in   (tok_in_v[gi]),
                .psum_in  (psum_in_v[gi]),
                .hold     (hold_v[gi]),
                .pass     (pass_v[gi]),
                .wrap_hit (wrap_v[gi]),
                .old_hit  (old_v[gi]),
                .psum     (psum_v[gi])
            );
        end
    endgenerate

    // Stage 2: window update and report decision
    assign is_crit  = (s1_cls_reg == taw_pkg::LVL_CRIT);
    assign is_norm  = (s1_cls_reg == taw_pkg::LVL_NORMAL);
    assign new_mark = !is_norm;
    assign old_mark = |old_v;

    // Replace the overwritten mark in the running count
    assign cnt_after = count_reg - CW'(old_mark) + CW'(new_mark);

    assign recover_hit = is_norm && (rep_reg != taw_pkg::LVL_NORMAL)
                         && (tally_reg >= recover_count_reg);
    assign clear_now   = is_crit || recover_hit;

    assign cell_ctl.write = adv && !is_crit;
    assign cell_ctl.clear = adv && clear_now;
    assign cell_ctl.mark  = new_mark;
    assign cell_ctl.stray = ~|hold_v;

    always_comb
    begin
        rep_next  = rep_reg;
        rep_valid = 1'b0;
        rep_level = taw_pkg::LVL_NORMAL;
        target    = is_crit ? taw_pkg::LVL_CRIT : taw_pkg::LVL_WARN;
        raise     = is_crit || (32'(cnt_after) >= 32'(warn_count_reg));
        if (is_norm)
        begin
            if (recover_hit)
            begin
                rep_next  = taw_pkg::LVL_NORMAL;
                rep_valid = 1'b1;
            end
        end
        else if (raise && (rep_reg != target))
        begin
            rep_next  = target;
            rep_valid = 1'b1;
            rep_level = target;
        end
    end

    always_comb
    begin
        tally_next = tally_reg;
        if (clear_now)
        begin
            tally_next = '0;
        end
        else if (is_norm && (rep_reg != taw_pkg::LVL_NORMAL) && (tally_reg != '1))
        begin
            tally_next = tally_reg + TW'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (adv)
        begin
            count_next = clear_now ? '0 : cnt_after;
        end
        else if (sync_reg == YW'(1))
        begin
            // Recount settled at the far end of the row
            count_next = psum_v[WINDOW_MAX-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cls_reg  <= taw_pkg::LVL_NORMAL;
            rep_reg       <= taw_pkg::LVL_NORMAL;
            tally_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (adv)
            begin
                prev_cls_reg  <= s1_cls_reg;
                rep_reg       <= rep_next;
                tally_reg     <= tally_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            check_level_reg   <= s1_cls_reg;
            level_changed_reg <= (s1_cls_reg != prev_cls_reg);
            report_valid_reg  <= rep_valid;
            report_level_reg  <= rep_level;
        end
    end

    assign out_valid     = out_valid_reg;
    assign check_level   = check_level_reg;
    assign level_changed = level_changed_reg;
    assign report_valid  = report_valid_reg;
    assign report_level  = report_level_reg;

endmodule

/* design/taw_chk.sv */
// Port-level checker for the threshold alarm with window block, bound to the top level.
// Depends on taw_pkg and threshold_alarm_with_window_unit.
module taw_chk
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic signed [taw_pkg::DATA_W-1:0]  sample,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic        [taw_pkg::LEVEL_W-1:0] check_level,
    input logic                               level_changed,
    input logic                               report_valid,
    input logic        [taw_pkg::LEVEL_W-1:0] report_level
);

    logic [taw_pkg::LEVEL_W-1:0] last_cls_reg;

    // Track the class of the last delivered transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cls_reg <= taw_pkg::LVL_NORMAL;
        end
        else if (out_valid && !out_stall)
        begin
            last_cls_reg <= check_level;
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(sample)))
        else $error("stalled input transaction changed");

    a_changed_tracks_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (level_changed == (check_level != last_cls_reg)))
        else $error("level_changed disagrees with the previous transaction's class");

    a_report_matches_class: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_valid) |-> (report_level == check_level))
        else $error("report level differs from the class of its sample");

    a_no_report_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !report_valid) |-> (report_level == taw_pkg::LVL_NORMAL))
        else $error("report_level set without a report");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(check_level)
            && $stable(level_changed) && $stable(report_valid) && $stable(report_level)))
        else $error("stalled result changed");

endmodule

bind threshold_alarm_with_window_unit taw_chk u_taw_chk (.*);
